### sv/counting_semaphore_wait_stack_assert.svh
// Assertion macros for the counting semaphore wait stack.
// Included by the top level; no other dependencies.
`ifndef COUNTING_SEMAPHORE_WAIT_STACK_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAIT_STACK_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define CSWS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csws assertion failed");
// Next-cycle implication.
`define CSWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csws assertion failed");
`else
`define CSWS_ASSERT_IMP(label, clk, rst, ante, cons)
`define CSWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/csws_pkg.sv
// Shared types and codes of the counting semaphore wait stack.
// No dependencies; used by csws_cell and the top level.
`timescale 1ns / 1ps
`default_nettype none
package csws_pkg;

   localparam int MAX_WAITERS_DEF    = 16;
   localparam int THREAD_ID_BITS_DEF = 8;

   localparam int KIND_W   = 2;
   localparam int TID_W    = 8;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 3;

   localparam logic [KIND_W-1:0] KIND_GET     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PUT     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SUSPENDED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PUT_IDLE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PUT_WOKE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd6;

   // Stack operation applied to every cell in the same cycle.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP,
      CELL_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        shift;     // this cell lies at or above the removed entry
      logic        occupied;  // this cell holds a waiter
   } cell_ctrl_type;

endpackage
`default_nettype wire

### sv/csws_cell.sv
// One slot of the wait stack: holds a thread id and flags a match.
// Depends on csws_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csws_cell
   import csws_pkg::*;
#(
   parameter int ID_W = THREAD_ID_BITS_DEF
) (
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic [ID_W-1:0] tid,
   input  wire logic [ID_W-1:0] id_below,
   input  wire logic [ID_W-1:0] id_above,
   output logic [ID_W-1:0]      id_out,
   output logic                 hit_out
);

   logic [ID_W-1:0] id_ff;
   logic [ID_W-1:0] id_in;
   logic            hit_ff;
   logic            hit_in;

   always_comb begin
      case (ctrl.op)
         CELL_PUSH:   id_in = id_below;
         CELL_POP:    id_in = id_above;
         CELL_REMOVE: id_in = ctrl.shift ? id_above : id_ff;
         default:     id_in = id_ff;
      endcase
      hit_in = ctrl.occupied && (id_ff == tid);
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      hit_ff <= hit_in;
   end

   assign id_out  = id_ff;
   assign hit_out = hit_ff;

endmodule
`default_nettype wire

### sv/counting_semaphore_wait_stack.sv
// Top level of the counting semaphore with a LIFO stack of waiting threads.
// Depends on csws_pkg, csws_cell and counting_semaphore_wait_stack_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "counting_semaphore_wait_stack_assert.svh"

// Counting semaphore with a wait stack held in a row of cells, the newest
// waiter in cell 0. A get takes a unit or pushes the thread (overflow when
// full); a put adds its amount (saturating at 65535) and hands one unit to
// the newest waiter; a timeout removes the newest matching waiter. Every
// item steps through S_IDLE, which takes the beat, S_CMP, in which every cell
// registers its id compare, and S_APPLY, in which the cells shift and the
// result is loaded into the response register. A stalled response holds
// S_APPLY until the response register frees up. Writing csr_wr_data loads
// the count and empties the stack; write it only while no item is in flight.
module counting_semaphore_wait_stack
   import csws_pkg::*;
#(
   parameter int MAX_WAITERS    = MAX_WAITERS_DEF,
   parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [23:0]         req_tdata,   // thread_id[7:0], put_amount[23:8]
   input  wire logic [KIND_W-1:0]   req_tuser,   // kind[1:0]
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [23:0]              rsp_tdata,   // woken_thread[7:0], count_after[23:8]
   output logic [STATUS_W-1:0]      rsp_tuser,   // status[2:0]
   input  wire logic                csr_wr_en,
   input  wire logic [COUNT_W-1:0]  csr_wr_data  // initial_count[15:0]
);

   localparam int ID_W  = THREAD_ID_BITS;
   localparam int CNT_W = $clog2(MAX_WAITERS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CMP,
      S_APPLY
   } state_type;

   state_type            state_ff, state_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [ID_W-1:0]      tid_ff, tid_in;
   logic [COUNT_W-1:0]   amount_ff, amount_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [TID_W-1:0]     rsp_woken_ff, rsp_woken_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [ID_W-1:0]      cell_id [MAX_WAITERS];
   logic [MAX_WAITERS-1:0] hits;
   logic [MAX_WAITERS-1:0] shifts;
   cell_ctrl_type        cell_ctrl [MAX_WAITERS];
   cell_op_type          op;
   logic                 go;
   logic                 full;
   logic [TID_W+ID_W-1:0] tid_ext;
   logic [TID_W+ID_W-1:0] tid_wide;
   logic [TID_W+ID_W-1:0] top_ext;
   logic [COUNT_W:0]     put_sum;
   logic [COUNT_W-1:0]   put_sat;
   logic                 woke_now;
   logic                 grant_now;

   // Keep the low id bits of the request; zero-extend when ids are wider.
   assign tid_ext  = {{ID_W{1'b0}}, req_tdata[TID_W-1:0]};
   assign tid_wide = {{TID_W{1'b0}}, tid_ff};
   assign top_ext  = {{TID_W{1'b0}}, cell_id[0]};
   assign full     = (total_ff == CNT_W'(MAX_WAITERS));
   assign go       = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_tready);
   assign put_sum  = {1'b0, count_ff} + {1'b0, amount_ff};
   assign put_sat  = put_sum[COUNT_W] ? {COUNT_W{1'b1}} : put_sum[COUNT_W-1:0];

   genvar gi;
   generate
      for (gi = 0; gi < MAX_WAITERS; gi++) begin : g_cell
         logic [ID_W-1:0] below_w;
         logic [ID_W-1:0] above_w;

         // Newest match is the lowest hit; it and every cell above it move down.
         assign shifts[gi] = |hits[gi:0];
         assign cell_ctrl[gi] = '{op: op, shift: shifts[gi],
                                  occupied: (CNT_W'(gi) < total_ff)};

         if (gi == 0) begin : g_bot
            assign below_w = tid_ff;
         end else begin : g_mid
            assign below_w = cell_id[gi-1];
         end
         if (gi == MAX_WAITERS - 1) begin : g_top
            assign above_w = cell_id[gi];
         end else begin : g_low
            assign above_w = cell_id[gi+1];
         end

         csws_cell #(.ID_W(ID_W)) u_cell (
            .clock    (clock),
            .ctrl     (cell_ctrl[gi]),
            .tid      (tid_ff),
            .id_below (below_w),
            .id_above (above_w),
            .id_out   (cell_id[gi]),
            .hit_out  (hits[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      tid_in        = tid_ff;
      amount_in     = amount_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_woken_in  = rsp_woken_ff;
      rsp_count_in  = rsp_count_ff;
      op            = CELL_HOLD;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               tid_in    = tid_ext[ID_W-1:0];
               amount_in = req_tdata[TID_W +: COUNT_W];
               state_in  = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (go) begin
               rsp_woken_in = tid_wide[TID_W-1:0];
               case (kind_ff)
                  KIND_GET: begin
                     if (count_ff != '0) begin
                        count_in      = count_ff - COUNT_W'(1);
                        rsp_status_in = ST_GRANTED;
                     end else if (!full) begin
                        op            = CELL_PUSH;
                        total_in      = total_ff + CNT_W'(1);
                        rsp_status_in = ST_SUSPENDED;
                     end else begin
                        rsp_status_in = ST_OVERFLOW;
                     end
                  end
                  KIND_PUT: begin
                     if ((total_ff != '0) && (put_sat != '0)) begin
                        op            = CELL_POP;
                        count_in      = put_sat - COUNT_W'(1);
                        total_in      = total_ff - CNT_W'(1);
                        rsp_woken_in  = top_ext[TID_W-1:0];
                        rsp_status_in = ST_PUT_WOKE;
                     end else begin
                        count_in      = put_sat;
                        rsp_status_in = ST_PUT_IDLE;
                     end
                  end
                  KIND_TIMEOUT: begin
                     if (shifts[MAX_WAITERS-1]) begin
                        op            = CELL_REMOVE;
                        total_in      = total_ff - CNT_W'(1);
                        rsp_status_in = ST_REMOVED;
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               endcase
               rsp_count_in = count_in;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Setup write: load the count and drop all waiters.
      if (csr_wr_en) begin
         count_in = csr_wr_data;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      tid_ff        <= tid_in;
      amount_ff     <= amount_in;
      rsp_status_ff <= rsp_status_in;
      rsp_woken_ff  <= rsp_woken_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_woken_ff};

   assign woke_now  = go && !csr_wr_en && (rsp_status_in == ST_PUT_WOKE);
   assign grant_now = go && !csr_wr_en && (rsp_status_in == ST_GRANTED);

   `CSWS_ASSERT_IMP(a_total_bound, clock, reset, 1'b1, total_ff <= CNT_W'(MAX_WAITERS))
   `CSWS_ASSERT_IMP(a_push_room, clock, reset, op == CELL_PUSH, !full)
   `CSWS_ASSERT_NEXT(a_pop, clock, reset, woke_now, total_ff == $past(total_ff) - CNT_W'(1))
   `CSWS_ASSERT_NEXT(a_grant, clock, reset, grant_now, count_ff == $past(count_ff) - COUNT_W'(1))

endmodule
`default_nettype wire
